>>> hdl/hfs_pkg.sv
// Package for the Hamming-windowed FFT spectrogram: payload types, controller command
// and status structs, and constant twiddle and window tables.
// Depends on nothing.
package hfs_pkg;

  localparam int LOG_N = 8;
  localparam int NPTS = 256;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               first;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  pair_index;
    logic [23:0] magnitude_even;
    logic [23:0] magnitude_odd;
    logic        last;
  } out_item_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic       load_rd;    // read ring entry at addr
    logic       load_wr;    // write weighted sample into bit-reversed slot
    logic       bf_rd;      // read butterfly operands
    logic       bf_mul;     // products
    logic       bf_wr;      // write butterfly results
    logic       mag_rd;     // read one bin
    logic       mag_sq;     // square components
    logic       sqrt_start; // launch square root
    logic [7:0] addr;       // sample index / bin
    logic [2:0] stage;
    logic [6:0] bfly;
  } dp_cmd_t;

  typedef struct packed {
    logic        sqrt_done;
    logic [23:0] mag;
  } dp_stat_t;

  // One 17-bit Q1.15 value per point.
  typedef logic [NPTS-1:0][16:0] q15_tbl_t;

  // Q30 cosine of 2 pi r / NPTS from a quarter-wave integer Taylor series.
  function automatic longint cos_q30(input int unsigned r);
    longint unsigned x, x2, term;
    longint sum;
    int unsigned m;
    logic neg;
    r = r % NPTS;
    neg = 1'b0;
    if (r <= NPTS / 4) m = r;
    else if (r <= NPTS / 2) begin m = NPTS / 2 - r; neg = 1'b1; end
    else if (r <= 3 * NPTS / 4) begin m = r - NPTS / 2; neg = 1'b1; end
    else m = NPTS - r;
    x = (64'd2 * 64'd3373259426 * m) / NPTS;
    x2 = (x * x) >> 30;
    term = 64'd1 << 30;
    sum = longint'(term);
    // Eight series terms; the divisors are (2n-1)(2n) for n = 1 to 8.
    term = ((term * x2) >> 30) / 64'd2;   sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd12;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd30;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd56;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd90;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd132; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd182; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd240; sum = sum + longint'(term);
    if (sum < 0) sum = 0;
    return neg ? -sum : sum;
  endfunction

  // Q30 cosine rounded to Q1.15 (magnitude half up).
  function automatic logic signed [16:0] cos_q15(input int unsigned r);
    longint c;
    c = cos_q30(r);
    if (c >= 0) return 17'((c + 16384) >>> 15);
    return 17'(-((-c + 16384) >>> 15));
  endfunction

  // Hamming coefficient in Q1.15.
  function automatic logic signed [16:0] ham_q15(input int unsigned k);
    longint c, p, h;
    c = cos_q30(k);
    p = 64'sd493921239 * c + (64'sd1 <<< 29);
    h = 64'sd579820585 - (p >>> 30);
    return 17'((h + 16384) >>> 15);
  endfunction

  function automatic q15_tbl_t cos_table(input int unsigned offset);
    q15_tbl_t t;
    for (int unsigned k = 0; k < NPTS; k++) t[k] = cos_q15(k + offset);
    return t;
  endfunction

  function automatic q15_tbl_t ham_table();
    q15_tbl_t t;
    for (int unsigned k = 0; k < NPTS; k++) t[k] = ham_q15(k);
    return t;
  endfunction

  // Constant twiddle and window tables, built at elaboration.
  localparam q15_tbl_t TW_COS = cos_table(0);
  localparam q15_tbl_t TW_SIN = cos_table(3 * NPTS / 4);
  localparam q15_tbl_t HAM_COEF = ham_table();

  function automatic logic [7:0] bitrev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[i] = v[7 - i];
    return r;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [41:0] v);
    if (v > 42'sd8388607) return 24'sh7FFFFF;
    if (v < -42'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

endpackage

>>> hdl/hfs_sqrt.sv
// Bit-serial integer square root, one result bit per cycle.
// Depends on hfs_pkg.
module hfs_sqrt
  import hfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [48:0] radicand,
  output logic        done,
  output logic [23:0] root
);

  logic [49:0] rem_r, rem_nxt;
  logic [49:0] res_r, res_nxt;
  logic [49:0] bit_r, bit_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [49:0] trial;

  // One restoring step per cycle over 25 bit pairs; done stays up until the next start.
  always_comb begin
    rem_nxt = rem_r;
    res_nxt = res_r;
    bit_nxt = bit_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    trial = res_r + bit_r;
    if (start) begin
      rem_nxt = {1'b0, radicand};
      res_nxt = '0;
      bit_nxt = 50'd1 << 48;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_nxt = rem_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[0]) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign done = done_r;
  assign root = (res_r > 50'd8388608) ? 24'd8388608 : res_r[23:0];

endmodule

>>> hdl/hfs_datapath.sv
// Datapath: sample ring, FFT buffer memory, window weighting, butterfly and magnitude.
// Depends on hfs_pkg and hfs_sqrt.
module hfs_datapath
  import hfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        ring_we,
  input  logic [7:0]  ring_head,
  input  logic signed [15:0] ring_din,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat
);

  logic signed [15:0] ring_mem [NPTS];
  logic [47:0]        fft_mem [NPTS];

  logic signed [15:0] ring_q_r;
  logic [7:0]         ld_idx_r;
  logic [47:0]        a_r, b_r;
  logic [7:0]         tw_r;
  logic signed [41:0] pre_r, pim_r, pcs_r, psr_r;
  logic signed [23:0] mre_r, mim_r;
  logic [48:0]        sq_r;
  logic [7:0]         lo_idx, hi_idx, hi_w, lo_w;
  logic [7:0]         half;
  logic signed [16:0] tc, ts, hc;
  logic signed [32:0] wprod;
  logic signed [23:0] wval;
  logic signed [23:0] are, aim, bre, bim, tre, tim;

  // Butterfly index: stage s has half = 2^s.
  always_comb begin
    half = 8'd1 << cmd.stage;
    lo_idx = 8'(((cmd.bfly >> cmd.stage) << (cmd.stage + 3'd1)) |
                (cmd.bfly & 7'(half - 8'd1)));
    hi_idx = lo_idx | half;
  end

  // Sample ring, written on accept.
  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[ring_head] <= ring_din;
    if (cmd.load_rd) begin
      ring_q_r <= ring_mem[8'(ring_head + cmd.addr)];
      ld_idx_r <= cmd.addr;
    end
  end

  // Window weighting with round half up.
  always_comb begin
    hc = HAM_COEF[ld_idx_r];
    wprod = ring_q_r * hc;
    wval = 24'((wprod + 33'sd16384) >>> 15);
  end

  // Twiddle lookup and operand split.
  always_comb begin
    tc = TW_COS[tw_r];
    ts = TW_SIN[tw_r];
    are = a_r[47:24];
    aim = a_r[23:0];
    bre = b_r[47:24];
    bim = b_r[23:0];
    tre = sat24((pre_r + pim_r + 42'sd16384) >>> 15);
    tim = sat24((pcs_r - psr_r + 42'sd16384) >>> 15);
  end

  always_ff @(posedge clk) begin
    if (cmd.bf_rd) begin
      a_r <= fft_mem[lo_idx];
      b_r <= fft_mem[hi_idx];
      tw_r <= 8'((cmd.bfly & 7'(half - 8'd1)) << (3'd7 - cmd.stage));
      lo_w <= lo_idx;
      hi_w <= hi_idx;
    end
    if (cmd.bf_mul) begin
      pre_r <= 42'(bre * tc);
      pim_r <= 42'(bim * ts);
      pcs_r <= 42'(bim * tc);
      psr_r <= 42'(bre * ts);
    end
    if (cmd.load_wr) begin
      fft_mem[bitrev8(ld_idx_r)] <= {wval, 24'd0};
    end else if (cmd.bf_wr) begin
      fft_mem[lo_w] <= {sat24(42'(are) + 42'(tre)), sat24(42'(aim) + 42'(tim))};
      fft_mem[hi_w] <= {sat24(42'(are) - 42'(tre)), sat24(42'(aim) - 42'(tim))};
    end
    if (cmd.mag_rd) begin
      mre_r <= fft_mem[cmd.addr][47:24];
      mim_r <= fft_mem[cmd.addr][23:0];
    end
    if (cmd.mag_sq) sq_r <= 49'(48'(mre_r * mre_r)) + 49'(48'(mim_r * mim_r));
  end

  hfs_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (sq_r),
    .done     (stat.sqrt_done),
    .root     (stat.mag)
  );

endmodule

>>> hdl/hfs_ctrl.sv
// Controller: window counting, sequencing of load, FFT stages and magnitude output.
// Depends on hfs_pkg.
module hfs_ctrl
  import hfs_pkg::*;
#(
  parameter int HOP = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  output logic       ring_we,
  output logic [7:0] ring_head,
  output dp_cmd_t    cmd,
  input  dp_stat_t   stat
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_LOAD = 8'b00000010,
    S_BFR  = 8'b00000100,
    S_BFM  = 8'b00001000,
    S_BFW  = 8'b00010000,
    S_MRD  = 8'b00100000,
    S_MSQ  = 8'b01000000,
    S_MSR  = 8'b10000000
  } state_t;

  localparam int HW = $clog2(HOP + 1);

  state_t      st_r, st_nxt;
  logic [8:0]  cnt_r, cnt_nxt;
  logic [HW-1:0] hop_r, hop_nxt;
  logic [7:0]  head_r, head_nxt;
  logic [8:0]  idx_r, idx_nxt;
  logic [2:0]  stage_r, stage_nxt;
  logic        odd_r, odd_nxt;
  logic [23:0] even_r, even_nxt;
  logic        ov_r, ov_nxt;
  out_item_t   od_r, od_nxt;
  logic        acc, emit;
  logic [8:0]  cnt_b;
  logic [HW-1:0] hop_b;

  assign in_ready = (st_r == S_IDLE);
  assign acc = in_valid && in_ready;
  assign ring_we = acc;
  assign ring_head = head_r;
  assign out_valid = ov_r;
  assign out_data = od_r;

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; hop_nxt = hop_r; head_nxt = head_r;
    idx_nxt = idx_r; stage_nxt = stage_r; odd_nxt = odd_r; even_nxt = even_r;
    ov_nxt = ov_r; od_nxt = od_r; emit = 1'b0;
    cnt_b = in_data.first ? 9'd0 : cnt_r;
    hop_b = in_data.first ? '0 : hop_r;
    cmd = '0;
    cmd.addr = idx_r[7:0];
    cmd.stage = stage_r;
    cmd.bfly = idx_r[6:0];
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (acc) begin
          head_nxt = head_r + 8'd1;
          if (cnt_b < 9'(NPTS)) begin
            cnt_nxt = cnt_b + 9'd1;
            hop_nxt = hop_b;
            if (cnt_b + 9'd1 == 9'(NPTS)) begin emit = 1'b1; hop_nxt = '0; end
          end else begin
            cnt_nxt = cnt_b;
            hop_nxt = hop_b + 1'b1;
            if (hop_b + 1'b1 >= HW'(HOP)) begin emit = 1'b1; hop_nxt = '0; end
          end
          if (emit) begin st_nxt = S_LOAD; idx_nxt = '0; end
        end
      end
      // Read one ring entry per cycle, write the weighted value in the cycle after.
      S_LOAD: begin
        cmd.load_rd = (idx_r < 9'(NPTS));
        cmd.load_wr = (idx_r != 9'd0);
        idx_nxt = idx_r + 9'd1;
        if (idx_r == 9'(NPTS)) begin
          st_nxt = S_BFR; idx_nxt = '0; stage_nxt = '0;
        end
      end
      S_BFR: begin cmd.bf_rd = 1'b1; st_nxt = S_BFM; end
      S_BFM: begin cmd.bf_mul = 1'b1; st_nxt = S_BFW; end
      S_BFW: begin
        cmd.bf_wr = 1'b1;
        st_nxt = S_BFR;
        idx_nxt = idx_r + 9'd1;
        if (idx_r == 9'(NPTS / 2 - 1)) begin
          idx_nxt = '0;
          stage_nxt = stage_r + 3'd1;
          if (stage_r == 3'(LOG_N - 1)) begin st_nxt = S_MRD; odd_nxt = 1'b0; end
        end
      end
      S_MRD: begin cmd.mag_rd = 1'b1; st_nxt = S_MSQ; end
      S_MSQ: begin cmd.mag_sq = 1'b1; st_nxt = S_MSR; end
      S_MSR: begin
        if (idx_r[0] && (ov_r && !out_ready)) begin
          // wait for the output register to free up
        end else begin
          if (!cmd.sqrt_start && stat.sqrt_done) begin
            if (!idx_r[0]) begin
              even_nxt = stat.mag;
              idx_nxt = idx_r + 9'd1;
              st_nxt = S_MRD;
            end else begin
              ov_nxt = 1'b1;
              od_nxt.pair_index = idx_r[6:1];
              od_nxt.magnitude_even = even_r;
              od_nxt.magnitude_odd = stat.mag;
              od_nxt.last = (idx_r == 9'(NPTS / 2 - 1));
              idx_nxt = idx_r + 9'd1;
              st_nxt = (idx_r == 9'(NPTS / 2 - 1)) ? S_IDLE : S_MRD;
            end
          end
        end
        cmd.sqrt_start = !odd_r;
        odd_nxt = 1'b1;
        if (st_nxt != S_MSR) odd_nxt = 1'b0;
      end
      default: st_nxt = S_IDLE;
    endcase
    if (st_r == S_MSR && odd_r == 1'b0) begin
      // first cycle of square root: do not consume stale done
      st_nxt = S_MSR; ov_nxt = (ov_r && out_ready) ? 1'b0 : ov_r; od_nxt = od_r;
      even_nxt = even_r; idx_nxt = idx_r; odd_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; cnt_r <= '0; hop_r <= '0; head_r <= '0; ov_r <= 1'b0;
      idx_r <= '0; stage_r <= '0; odd_r <= 1'b0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; hop_r <= hop_nxt; head_r <= head_nxt;
      ov_r <= ov_nxt; idx_r <= idx_nxt; stage_r <= stage_nxt; odd_r <= odd_nxt;
    end
    even_r <= even_nxt;
    od_r <= od_nxt;
  end

endmodule

>>> hdl/hamming_fft_spectrogram_top.sv
// Top level of the Hamming-windowed FFT spectrogram.
// Depends on hfs_pkg, hfs_ctrl and hfs_datapath.
//
// Samples are taken one per transaction while the block is idle. When a
// window is due (256 samples after a restart, then every HOP samples) the
// block stops taking samples for one spectrum: it weights and loads the FFT
// memory, runs 1024 butterflies through a single shared butterfly unit, and
// passes 128 bins through the bit-serial square root. The 64 results leave
// through a one-entry output register and a stalled output channel holds
// the sequence back.
module hamming_fft_spectrogram_top
  import hfs_pkg::*;
#(
  parameter int HOP = 128
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic       ring_we;
  logic [7:0] ring_head;

  hfs_ctrl #(.HOP(HOP)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .ring_we, .ring_head, .cmd, .stat
  );

  hfs_datapath u_dp (
    .clk, .rst_n, .ring_we, .ring_head, .ring_din(in_data.sample), .cmd, .stat
  );

  // Only one memory read kind at a time.
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_rd, cmd.bf_rd, cmd.mag_rd})) else $error("cmd clash");
  // No samples taken while results are pending in the sequence.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last) |-> !in_ready) else $error("ready early");
  // A pending result holds until taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result dropped");

endmodule

>>> verif/testbench.sv
// Self-checking testbench for hamming_fft_spectrogram_top.
// Depends on hfs_pkg and the RTL; an in-bench spectrum predictor supplies the expected bin pairs.
module testbench;
  import hfs_pkg::*;

  localparam int WIN = 256;
  localparam int HOPLEN = 128;
  localparam int HOLD_CYCLES = 12000;

  // Spectrum predictor and store of expected bin pairs.
  class spectrum_board;
    logic signed [15:0] ring [WIN];
    int unsigned        count;
    int unsigned        hop;
    int unsigned        head;
    longint             twc [WIN];
    longint             tws [WIN];
    longint             coef [WIN];
    out_item_t          pairs_due [$];

    function new();
      longint c;
      longint s;
      longint h;
      count = 0;
      hop = 0;
      head = 0;
      for (int k = 0; k < WIN; k++) begin
        ring[k] = '0;
        c = cosine_q30(k);
        s = cosine_q30(k + 3 * (WIN / 4));
        h = 64'sd579820585 - rnd_shift(64'sd493921239 * c, 30);
        twc[k] = to_q15(c);
        tws[k] = to_q15(s);
        coef[k] = rnd_shift(h, 15);
      end
    endfunction

    static function longint rnd_shift(longint v, int sh);
      return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    static function longint clip24(longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
    endfunction

    static function longint to_q15(longint v);
      if (v >= 0) return (v + 16384) >>> 15;
      return -((-v + 16384) >>> 15);
    endfunction

    // Quarter-wave Taylor series of cos(2 pi m / WIN) in Q30.
    static function longint quarter_cos(int unsigned m);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint sum;
      x = (64'd2 * 64'd3373259426 * m) / WIN;
      x2 = (x * x) >> 30;
      term = 64'd1 << 30;
      sum = longint'(term);
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
        if (n % 2 == 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      return sum;
    endfunction

    static function longint cosine_q30(int unsigned r);
      r = r % WIN;
      if (r <= WIN / 4) return quarter_cos(r);
      if (r <= WIN / 2) return -quarter_cos(WIN / 2 - r);
      if (r <= 3 * WIN / 4) return -quarter_cos(r - WIN / 2);
      return quarter_cos(WIN - r);
    endfunction

    static function int unsigned flip8(int unsigned v);
      int unsigned r;
      r = 0;
      for (int i = 0; i < 8; i++) r = (r << 1) | ((v >> i) & 1);
      return r;
    endfunction

    static function longint unsigned root_floor(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    static function logic [23:0] bin_mag(longint re, longint im);
      longint unsigned m;
      m = root_floor(longint'(re * re) + longint'(im * im));
      if (m > 64'd8388608) m = 64'd8388608;
      return m[23:0];
    endfunction

    // Windowed FFT over the ring, oldest sample first; queues 64 bin pairs.
    function void run_spectrum();
      longint re [WIN];
      longint im [WIN];
      longint ar, ai, tr, ti, c, s;
      int half, stride;
      out_item_t p;
      for (int n = 0; n < WIN; n++) begin
        re[flip8(n)] = clip24(rnd_shift(longint'(ring[(head + n) % WIN]) * coef[n], 15));
        im[flip8(n)] = 0;
      end
      for (int len = 2; len <= WIN; len <<= 1) begin
        half = len / 2;
        stride = WIN / len;
        for (int base = 0; base < WIN; base += len) begin
          for (int i = 0; i < half; i++) begin
            c = twc[i * stride];
            s = tws[i * stride];
            ar = re[base + i];
            ai = im[base + i];
            tr = clip24(rnd_shift(re[base + i + half] * c + im[base + i + half] * s, 15));
            ti = clip24(rnd_shift(im[base + i + half] * c - re[base + i + half] * s, 15));
            re[base + i] = clip24(ar + tr);
            im[base + i] = clip24(ai + ti);
            re[base + i + half] = clip24(ar - tr);
            im[base + i + half] = clip24(ai - ti);
          end
        end
      end
      for (int k = 0; k < WIN / 4; k++) begin
        p.pair_index = 6'(k);
        p.magnitude_even = bin_mag(re[2 * k], im[2 * k]);
        p.magnitude_odd = bin_mag(re[2 * k + 1], im[2 * k + 1]);
        p.last = (k == WIN / 4 - 1);
        pairs_due.push_back(p);
      end
    endfunction

    // Accepted input transaction.
    function void note_sample(in_item_t it);
      bit due;
      due = 0;
      if (it.first) begin
        count = 0;
        hop = 0;
      end
      ring[head] = it.sample;
      head = (head + 1) % WIN;
      if (count < WIN) begin
        count++;
        if (count == WIN) begin
          due = 1;
          hop = 0;
        end
      end else begin
        hop++;
        if (hop >= HOPLEN) begin
          due = 1;
          hop = 0;
        end
      end
      if (due) run_spectrum();
    endfunction

    // Accepted result transaction; returns 0 and a message on a mismatch.
    function bit check_pair(out_item_t got, output string msg);
      out_item_t want;
      msg = "";
      if (pairs_due.size() == 0) begin
        $sformat(msg, "unexpected result pair %0d", got.pair_index);
        return 0;
      end
      want = pairs_due.pop_front();
      if (got.pair_index !== want.pair_index || got.magnitude_even !== want.magnitude_even ||
          got.magnitude_odd !== want.magnitude_odd || got.last !== want.last) begin
        $sformat(msg, "pair got %0d/%0d/%0d/%0d want %0d/%0d/%0d/%0d",
                 got.pair_index, got.magnitude_even, got.magnitude_odd, got.last,
                 want.pair_index, want.magnitude_even, want.magnitude_odd, want.last);
        return 0;
      end
      return 1;
    endfunction

    function int pending();
      return pairs_due.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  spectrum_board board;
  int  failures;
  bit  hold_req;
  int  burst_left;

  hamming_fft_spectrogram_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  task automatic report(string msg);
    $display("MISMATCH: %s", msg);
    failures++;
  endtask

  // One input transaction, with burst and gap idling in front of it.
  task automatic send_sample(logic signed [15:0] smp, logic first);
    in_item_t it;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    it.sample = smp;
    it.first = first;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_sample(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Result side: check every accepted transaction.
  always @(posedge clk) begin
    string msg;
    if (rst_n && out_valid && out_ready) begin
      if (!board.check_pair(out_data, msg)) report(msg);
    end
  end

  // Receiver stall pattern, with one long hold-off on request.
  initial begin
    int mode;
    out_ready = 1'b0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: begin
          out_ready <= 1'b1;
        end
        1: begin
          out_ready <= 1'($urandom_range(0, 1));
        end
        default: begin
          out_ready <= ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  // Timeout.
  initial begin
    #400000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    logic signed [15:0] dir [12];
    int kind;
    logic signed [15:0] smp;
    board = new();
    failures = 0;
    hold_req = 0;
    burst_left = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes and restarts, too short to finish a window.
    dir = '{16'sh7FFF, -16'sh8000, 16'sh0000, 16'sh0001, -16'sh0001, 16'sh5555,
            -16'sh5556, 16'sh7FFE, -16'sh7FFF, 16'sh4000, -16'sh4000, 16'sh0100};
    for (int i = 0; i < 24; i++) send_sample(dir[i % 12], (i == 0 || i == 13));

    // Segments that start with a restart: one long enough for a window, whose
    // results meet a long receiver hold-off, then short ones that finish none.
    for (int seg = 0; seg < 4; seg++) begin
      kind = seg;
      for (int i = 0; i < ((seg == 0) ? 262 : 10); i++) begin
        if (seg == 0 && i == 250) hold_req = 1;
        case (kind)
          0: smp = 16'($urandom);
          1: smp = 16'(int'($urandom_range(0, 255)) - 128);
          2: smp = ($urandom_range(0, 1)) ? 16'sh7FFF : -16'sh8000;
          default: begin
            if ($urandom_range(0, 3) == 0) smp = 16'($urandom);
            else smp = ((i / 8) % 2) ? 16'sh7FFF : -16'sh8000;
          end
        endcase
        send_sample(smp, (i == 0));
      end
      if (seg == 0) wait_drained();
    end

    wait_drained();
    repeat (300) @(posedge clk);
    if (failures == 0 && board.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
